// ----- rtl/rpd_pkg.sv -----
// shared types, constants and reset values of the proximity door block
package rpd_pkg;

	// tracker phase of one mode
	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_APPEAR = 2'd1,
		PH_STRONG = 2'd2,
		PH_LEAVE  = 2'd3
	} phase_t;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_APPEAR = 2'd0,
		REG_STRONG = 2'd1,
		REG_SUDDEN = 2'd2,
		REG_GRACE  = 2'd3
	} reg_idx_t;

	// sighting modes
	localparam logic MODE_SCAN    = 1'b0;
	localparam logic MODE_CLASSIC = 1'b1;

	// configuration port geometry
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// reset values of the registers
	localparam logic signed [7:0] APPEAR_RST = -8'sd95;
	localparam logic signed [7:0] STRONG_RST = -8'sd80;
	localparam logic signed [7:0] SUDDEN_RST = -8'sd55;
	localparam logic [15:0]       GRACE_RST  = 16'd10000;

	// minimum rssi move that counts as a classic edge
	localparam logic [8:0] EDGE_DELTA = 9'd5;

	typedef struct packed {
		logic signed [7:0] appear_threshold;
		logic signed [7:0] strong_threshold;
		logic signed [7:0] sudden_threshold;
		logic [15:0]       boot_grace_ms;
	} cfg_t;

	typedef struct packed {
		logic              mode;
		logic signed [7:0] rssi;
		logic              seen;
		logic              lost;
		logic              open_accepted;
		logic [31:0]       time_ms;
	} item_t;

	typedef struct packed {
		logic       open_request;
		logic       close_request;
		logic [1:0] phase_now;
		logic       armed_now;
		logic       evaluated;
	} res_t;

endpackage

// ----- rtl/rpd_ifs.sv -----
// valid/ready channel interfaces for sightings and results

interface rpd_in_if;
	logic              valid;
	logic              ready;
	logic              mode;
	logic signed [7:0] rssi;
	logic              seen;
	logic              lost;
	logic              open_accepted;
	logic [31:0]       time_ms;

	modport source (output valid, mode, rssi, seen, lost, open_accepted, time_ms,
		input ready);
	modport sink (input valid, mode, rssi, seen, lost, open_accepted, time_ms,
		output ready);
endinterface

interface rpd_out_if;
	logic       valid;
	logic       ready;
	logic       open_request;
	logic       close_request;
	logic [1:0] phase_now;
	logic       armed_now;
	logic       evaluated;

	modport source (output valid, open_request, close_request, phase_now, armed_now,
		evaluated, input ready);
	modport sink (input valid, open_request, close_request, phase_now, armed_now,
		evaluated, output ready);
endinterface

// ----- rtl/rssi_proximity_door_fsm_unit.sv -----
// top level of the rssi proximity door controller
// path: an item taken sits in the input register; its result is then loaded into the
// output register and offered until it is taken
// throughput: one item per cycle while the output is not stalled; a stalled
// output holds one result while one more item waits in the input register
// reset: arst_n clears trackers, arming and classic history and loads register defaults
module rssi_proximity_door_fsm_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	rpd_in_if.sink                      in_ch,
	rpd_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpd_pkg::PADDR_W-1:0] paddr,
	input  logic [rpd_pkg::PDATA_W-1:0] pwdata,
	output logic [rpd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	rpd_pkg::cfg_t  cfg;
	rpd_pkg::item_t item_s1;
	rpd_pkg::res_t  res, res_q;
	logic           valid_s1, out_valid_q, fire;

	// input item moves on when the output register is free or being emptied
	assign fire         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || fire;

	rpd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.mode          <= in_ch.mode;
			item_s1.rssi          <= in_ch.rssi;
			item_s1.seen          <= in_ch.seen;
			item_s1.lost          <= in_ch.lost;
			item_s1.open_accepted <= in_ch.open_accepted;
			item_s1.time_ms       <= in_ch.time_ms;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.open_request  = res_q.open_request;
	assign out_ch.close_request = res_q.close_request;
	assign out_ch.phase_now     = res_q.phase_now;
	assign out_ch.armed_now     = res_q.armed_now;
	assign out_ch.evaluated     = res_q.evaluated;

	// a waiting item never overwrites a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !fire)
		else $error("result register overwritten while stalled");

	// an item that moves on from the input register is in the output register in the next cycle
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost after the input stage");
endmodule

// ----- rtl/rpd_cfg_regs.sv -----
// configuration registers behind the apb-style port
module rpd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpd_pkg::PADDR_W-1:0] paddr,
	input  logic [rpd_pkg::PDATA_W-1:0] pwdata,
	output logic [rpd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output rpd_pkg::cfg_t               cfg
);
	rpd_pkg::cfg_t     cfg_q;
	rpd_pkg::reg_idx_t idx;
	logic              wr_en;

	// word index and write strobe
	assign idx    = rpd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.appear_threshold <= rpd_pkg::APPEAR_RST;
			cfg_q.strong_threshold <= rpd_pkg::STRONG_RST;
			cfg_q.sudden_threshold <= rpd_pkg::SUDDEN_RST;
			cfg_q.boot_grace_ms    <= rpd_pkg::GRACE_RST;
		end else if (wr_en) begin
			unique case (idx)
				rpd_pkg::REG_APPEAR: cfg_q.appear_threshold <= pwdata[7:0];
				rpd_pkg::REG_STRONG: cfg_q.strong_threshold <= pwdata[7:0];
				rpd_pkg::REG_SUDDEN: cfg_q.sudden_threshold <= pwdata[7:0];
				rpd_pkg::REG_GRACE:  cfg_q.boot_grace_ms    <= pwdata[15:0];
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		unique case (idx)
			rpd_pkg::REG_APPEAR: prdata = {24'd0, cfg_q.appear_threshold};
			rpd_pkg::REG_STRONG: prdata = {24'd0, cfg_q.strong_threshold};
			rpd_pkg::REG_SUDDEN: prdata = {24'd0, cfg_q.sudden_threshold};
			rpd_pkg::REG_GRACE:  prdata = {16'd0, cfg_q.boot_grace_ms};
		endcase
	end
endmodule

// ----- rtl/rpd_core.sv -----
// tracker state, classification, classic edge gating and phase update
module rpd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  rpd_pkg::item_t item,
	input  rpd_pkg::cfg_t  cfg,
	output rpd_pkg::res_t  res
);
	rpd_pkg::phase_t   scan_phase_q, classic_phase_q;
	rpd_pkg::phase_t   cur_ph, nxt_ph;
	logic              close_armed_q, armed_nxt;
	logic              started_q, last_seen_q;
	logic signed [7:0] last_rssi_q;

	logic       sig, strong_sig, sudden, gone, edge_hit, eval;
	logic       open_req, try_close, set_arm, grace_over;
	logic [8:0] diff, mag;

	// classify the sighting
	assign sig        = item.seen && (item.rssi >= cfg.appear_threshold);
	assign strong_sig = sig && (item.rssi >= cfg.strong_threshold);
	assign sudden     = sig && (item.rssi >= cfg.sudden_threshold);
	assign gone       = (item.mode == rpd_pkg::MODE_CLASSIC) ? !item.seen
		: (!sig || item.lost);

	// classic edge: first sample, seen change or rssi move of five or more
	assign diff     = {item.rssi[7], item.rssi} - {last_rssi_q[7], last_rssi_q};
	assign mag      = diff[8] ? (~diff + 9'd1) : diff;
	assign edge_hit = !started_q || (item.seen != last_seen_q)
		|| (item.seen && (mag >= rpd_pkg::EDGE_DELTA));
	assign eval     = (item.mode == rpd_pkg::MODE_SCAN) || edge_hit;

	assign cur_ph     = (item.mode == rpd_pkg::MODE_CLASSIC) ? classic_phase_q : scan_phase_q;
	assign grace_over = item.time_ms >= {16'd0, cfg.boot_grace_ms};

	// phase transition of the selected tracker
	always_comb begin
		nxt_ph    = cur_ph;
		open_req  = 1'b0;
		try_close = 1'b0;
		set_arm   = 1'b0;
		unique case (cur_ph)
			rpd_pkg::PH_WAIT: begin
				if (sig && !sudden) begin
					open_req = 1'b1;
					set_arm  = item.open_accepted;
					nxt_ph   = rpd_pkg::PH_APPEAR;
				end else if (sudden) begin
					nxt_ph = rpd_pkg::PH_STRONG;
				end
			end
			rpd_pkg::PH_APPEAR: begin
				if (strong_sig) begin
					open_req = 1'b1;
					set_arm  = item.open_accepted;
					nxt_ph   = rpd_pkg::PH_STRONG;
				end else if (gone) begin
					try_close = 1'b1;
					nxt_ph    = rpd_pkg::PH_WAIT;
				end
			end
			rpd_pkg::PH_STRONG: begin
				if (!strong_sig && sig) begin
					set_arm = 1'b1;
					nxt_ph  = rpd_pkg::PH_LEAVE;
				end else if (gone) begin
					try_close = 1'b1;
					nxt_ph    = rpd_pkg::PH_WAIT;
				end
			end
			rpd_pkg::PH_LEAVE: begin
				if (gone) begin
					set_arm   = 1'b1;
					try_close = 1'b1;
					nxt_ph    = rpd_pkg::PH_WAIT;
				end else if (strong_sig) begin
					nxt_ph = rpd_pkg::PH_STRONG;
				end
			end
		endcase
	end

	assign armed_nxt = close_armed_q || (eval && set_arm);

	// result of this item
	assign res.open_request  = eval && open_req;
	assign res.close_request = eval && try_close && grace_over && armed_nxt;
	assign res.phase_now     = eval ? nxt_ph : cur_ph;
	assign res.armed_now     = armed_nxt;
	assign res.evaluated     = eval;

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_phase_q    <= rpd_pkg::PH_WAIT;
			classic_phase_q <= rpd_pkg::PH_WAIT;
			close_armed_q   <= 1'b0;
			started_q       <= 1'b0;
			last_seen_q     <= 1'b0;
			last_rssi_q     <= '0;
		end else if (fire && eval) begin
			close_armed_q <= armed_nxt;
			if (item.mode == rpd_pkg::MODE_CLASSIC) begin
				classic_phase_q <= nxt_ph;
				started_q       <= 1'b1;
				last_seen_q     <= item.seen;
				last_rssi_q     <= item.rssi;
			end else begin
				scan_phase_q <= nxt_ph;
			end
		end
	end

	// close only goes out once armed
	a_close_armed: assert property (@(posedge clk) disable iff (!arst_n)
		res.close_request |-> res.armed_now)
		else $error("close request while unarmed");

	// requests only on evaluated items
	a_req_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(res.open_request || res.close_request) |-> res.evaluated)
		else $error("request on an item that was not evaluated");

	// arming is never withdrawn
	a_armed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		close_armed_q |=> close_armed_q)
		else $error("close arming cleared");

	// a scan item leaves its reported phase behind
	a_scan_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == rpd_pkg::MODE_SCAN) |=>
		(scan_phase_q == $past(res.phase_now)))
		else $error("scan phase does not match reported phase");
endmodule

// ----- tb/rssi_proximity_door_fsm_unit_tb.sv -----
// self-checking testbench of the proximity door block: random bursts, stalls and register settings
module rssi_proximity_door_fsm_unit_tb;

	// sighting strength classes used to build approach and leave walks
	typedef enum int {
		LVL_GONE,
		LVL_WEAK,
		LVL_STRONG,
		LVL_SUDDEN
	} level_t;

	// receiver stall patterns
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_THIRD
	} stall_style_t;

	localparam int HOLD_AT_RESULT = 80;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_PHASE   = 145;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [rpd_pkg::PADDR_W-1:0]  paddr;
	logic [rpd_pkg::PDATA_W-1:0]  pwdata;
	logic [rpd_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	rpd_in_if  in_ch ();
	rpd_out_if out_ch ();

	rssi_proximity_door_fsm_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// sightings waiting to be sent and results they are owed
	rpd_pkg::item_t pending_sightings[$];
	rpd_pkg::res_t  expected_results[$];
	int    mismatch_count = 0;
	int    results_seen = 0;

	// own copy of registers and tracker state
	rpd_pkg::cfg_t   door_cfg;
	rpd_pkg::phase_t scan_track;
	rpd_pkg::phase_t classic_track;
	logic   door_armed;
	logic   classic_begun;
	logic   classic_prev_seen;
	int     classic_prev_rssi;

	// one phase step of a tracker, updates arming
	function automatic rpd_pkg::phase_t advance_tracker(rpd_pkg::phase_t ph, logic sig,
		logic strong_sig, logic sudden, logic gone, logic accepted, logic [31:0] now,
		output logic open_req, output logic close_req);
		rpd_pkg::phase_t nxt;
		logic            try_close;
		nxt = ph;
		try_close = 1'b0;
		open_req = 1'b0;
		close_req = 1'b0;
		case (ph)
			rpd_pkg::PH_WAIT: begin
				if (sig && !sudden) begin
					open_req = 1'b1;
					if (accepted) door_armed = 1'b1;
					nxt = rpd_pkg::PH_APPEAR;
				end else if (sudden) begin
					nxt = rpd_pkg::PH_STRONG;
				end
			end
			rpd_pkg::PH_APPEAR: begin
				if (strong_sig) begin
					open_req = 1'b1;
					if (accepted) door_armed = 1'b1;
					nxt = rpd_pkg::PH_STRONG;
				end else if (gone) begin
					try_close = 1'b1;
					nxt = rpd_pkg::PH_WAIT;
				end
			end
			rpd_pkg::PH_STRONG: begin
				if (!strong_sig && sig) begin
					door_armed = 1'b1;
					nxt = rpd_pkg::PH_LEAVE;
				end else if (gone) begin
					try_close = 1'b1;
					nxt = rpd_pkg::PH_WAIT;
				end
			end
			default: begin
				if (gone) begin
					door_armed = 1'b1;
					try_close = 1'b1;
					nxt = rpd_pkg::PH_WAIT;
				end else if (strong_sig) begin
					nxt = rpd_pkg::PH_STRONG;
				end
			end
		endcase
		if (try_close && now >= 32'(door_cfg.boot_grace_ms) && door_armed)
			close_req = 1'b1;
		return nxt;
	endfunction

	// expected result of one accepted sighting
	function automatic rpd_pkg::res_t predict_door_result(rpd_pkg::item_t s);
		rpd_pkg::res_t r;
		int   rssi_v;
		int   diff;
		logic sig, strong_sig, sudden, open_req, close_req, edge_hit;
		rssi_v = $signed(s.rssi);
		sig = s.seen && (rssi_v >= $signed(door_cfg.appear_threshold));
		strong_sig = sig && (rssi_v >= $signed(door_cfg.strong_threshold));
		sudden = sig && (rssi_v >= $signed(door_cfg.sudden_threshold));
		open_req = 1'b0;
		close_req = 1'b0;
		r.evaluated = 1'b0;
		if (s.mode == rpd_pkg::MODE_SCAN) begin
			r.evaluated = 1'b1;
			scan_track = advance_tracker(scan_track, sig, strong_sig, sudden,
				!sig || s.lost, s.open_accepted, s.time_ms, open_req, close_req);
			r.phase_now = scan_track;
		end else begin
			diff = rssi_v - classic_prev_rssi;
			if (diff < 0) diff = -diff;
			edge_hit = !classic_begun || (s.seen != classic_prev_seen) ||
				(s.seen && diff >= int'(rpd_pkg::EDGE_DELTA));
			if (edge_hit) begin
				r.evaluated = 1'b1;
				classic_begun = 1'b1;
				classic_prev_seen = s.seen;
				classic_prev_rssi = rssi_v;
				classic_track = advance_tracker(classic_track, sig, strong_sig, sudden,
					!s.seen, s.open_accepted, s.time_ms, open_req, close_req);
			end
			r.phase_now = classic_track;
		end
		r.open_request = open_req;
		r.close_request = close_req;
		r.armed_now = door_armed;
		return r;
	endfunction

	// random rssi in lo..hi, anywhere in -128..0 when that is empty
	function automatic int pick_rssi(int lo, int hi);
		if (lo > hi) return -int'($urandom_range(0, 128));
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// sighting of a given strength class under the current thresholds
	function automatic rpd_pkg::item_t make_sighting(logic mode, level_t lvl);
		rpd_pkg::item_t s;
		int    ap, st, su;
		ap = $signed(door_cfg.appear_threshold);
		st = $signed(door_cfg.strong_threshold);
		su = $signed(door_cfg.sudden_threshold);
		s.mode = mode;
		s.seen = 1'b1;
		s.lost = ($urandom_range(0, 15) == 0);
		s.open_accepted = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 3) == 0)
			s.time_ms = $urandom;
		else
			s.time_ms = $urandom_range(0, 2 * int'(door_cfg.boot_grace_ms) + 100);
		case (lvl)
			LVL_GONE: begin
				s.rssi = 8'(pick_rssi(-128, 0));
				case ($urandom_range(0, 2))
					0: s.seen = 1'b0;
					1: begin
						if (ap > -128) s.rssi = 8'(pick_rssi(-128, ap - 1));
						else s.seen = 1'b0;
					end
					default: s.lost = 1'b1;
				endcase
			end
			LVL_WEAK: s.rssi = 8'(pick_rssi(ap, ((st < su) ? st : su) - 1));
			LVL_STRONG: s.rssi = 8'(pick_rssi((ap > st) ? ap : st, su - 1));
			default: s.rssi = 8'(pick_rssi((ap > su) ? ap : su, 0));
		endcase
		return s;
	endfunction

	// sender: bursts of items with idle gaps, holds an item until it is taken
	always @(posedge clk or negedge arst_n) begin : sighting_driver
		rpd_pkg::item_t taken;
		rpd_pkg::item_t nxt;
		int    burst_left;
		int    idle_left;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= rpd_pkg::MODE_SCAN;
			in_ch.rssi <= '0;
			in_ch.seen <= 1'b0;
			in_ch.lost <= 1'b0;
			in_ch.open_accepted <= 1'b0;
			in_ch.time_ms <= '0;
			burst_left = 0;
			idle_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				taken = pending_sightings.pop_front();
				expected_results.push_back(predict_door_result(taken));
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_sightings.size() == 0) begin
					in_ch.valid <= 1'b0;
				end else begin
					nxt = pending_sightings[0];
					in_ch.valid <= 1'b1;
					in_ch.mode <= nxt.mode;
					in_ch.rssi <= nxt.rssi;
					in_ch.seen <= nxt.seen;
					in_ch.lost <= nxt.lost;
					in_ch.open_accepted <= nxt.open_accepted;
					in_ch.time_ms <= nxt.time_ms;
				end
			end
		end
	end

	// receiver: checks each result against the oldest expectation, stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin : result_monitor
		rpd_pkg::res_t want;
		int           hold_left;
		bit           hold_done;
		int           pattern_left;
		stall_style_t style;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
			pattern_left = 0;
			style = READY_ALWAYS;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no sighting owed: open_request %0b close_request %0b",
						out_ch.open_request, out_ch.close_request);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.open_request !== want.open_request) begin
						$error("open_request: expected %0b, got %0b", want.open_request,
							out_ch.open_request);
						mismatch_count++;
					end
					if (out_ch.close_request !== want.close_request) begin
						$error("close_request: expected %0b, got %0b", want.close_request,
							out_ch.close_request);
						mismatch_count++;
					end
					if (out_ch.phase_now !== want.phase_now) begin
						$error("phase_now: expected %0d, got %0d", want.phase_now,
							out_ch.phase_now);
						mismatch_count++;
					end
					if (out_ch.armed_now !== want.armed_now) begin
						$error("armed_now: expected %0b, got %0b", want.armed_now,
							out_ch.armed_now);
						mismatch_count++;
					end
					if (out_ch.evaluated !== want.evaluated) begin
						$error("evaluated: expected %0b, got %0b", want.evaluated,
							out_ch.evaluated);
						mismatch_count++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					style = stall_style_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(16, 96);
				end
				pattern_left--;
				case (style)
					READY_ALWAYS: out_ch.ready <= 1'b1;
					READY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default:      out_ch.ready <= (pattern_left % 3 == 0);
				endcase
			end
		end
	end

	// register write: setup cycle then access cycle
	task automatic write_register(rpd_pkg::reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rpd_pkg::REG_APPEAR: door_cfg.appear_threshold = value[7:0];
			rpd_pkg::REG_STRONG: door_cfg.strong_threshold = value[7:0];
			rpd_pkg::REG_SUDDEN: door_cfg.sudden_threshold = value[7:0];
			default:             door_cfg.boot_grace_ms = value[15:0];
		endcase
	endtask

	// all four registers, with junk in the unused upper bits
	task automatic set_thresholds(int appear, int strong_thr, int sudden, int grace);
		write_register(rpd_pkg::REG_APPEAR, {24'($urandom), 8'(appear)});
		write_register(rpd_pkg::REG_STRONG, {24'($urandom), 8'(strong_thr)});
		write_register(rpd_pkg::REG_SUDDEN, {24'($urandom), 8'(sudden)});
		write_register(rpd_pkg::REG_GRACE, {16'($urandom), 16'(grace)});
	endtask

	task automatic wait_drained();
		while (pending_sightings.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_sighting(logic mode, int rssi, logic seen, logic lost,
		logic accepted, logic [31:0] now);
		rpd_pkg::item_t s;
		s.mode = mode;
		s.rssi = 8'(rssi);
		s.seen = seen;
		s.lost = lost;
		s.open_accepted = accepted;
		s.time_ms = now;
		pending_sightings.push_back(s);
	endtask

	// mostly approach and leave walks through the strength classes, some noise
	task automatic run_random_phase(int count);
		int     made;
		int     walk_len;
		logic   mode;
		level_t lvl;
		rpd_pkg::item_t s;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 3) != 0) begin
				mode = 1'($urandom_range(0, 1));
				lvl = LVL_GONE;
				walk_len = $urandom_range(4, 12);
				repeat (walk_len) begin
					pending_sightings.push_back(make_sighting(mode, lvl));
					made++;
					if ($urandom_range(0, 7) == 0) mode = ~mode;
					case ($urandom_range(0, 5))
						0: ;
						1, 2: if (lvl != LVL_SUDDEN) lvl = level_t'(int'(lvl) + 1);
						3: if (lvl != LVL_GONE) lvl = level_t'(int'(lvl) - 1);
						4: lvl = LVL_GONE;
						default: lvl = level_t'($urandom_range(0, 3));
					endcase
				end
			end else begin
				s.mode = 1'($urandom_range(0, 1));
				s.rssi = 8'(-int'($urandom_range(0, 128)));
				s.seen = 1'($urandom_range(0, 1));
				s.lost = 1'($urandom_range(0, 1));
				s.open_accepted = 1'($urandom_range(0, 1));
				s.time_ms = $urandom;
				pending_sightings.push_back(s);
				made++;
			end
		end
	endtask

	// stimulus and end of run
	initial begin : stimulus
		int ap, st, su;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		door_cfg.appear_threshold = rpd_pkg::APPEAR_RST;
		door_cfg.strong_threshold = rpd_pkg::STRONG_RST;
		door_cfg.sudden_threshold = rpd_pkg::SUDDEN_RST;
		door_cfg.boot_grace_ms = rpd_pkg::GRACE_RST;
		scan_track = rpd_pkg::PH_WAIT;
		classic_track = rpd_pkg::PH_WAIT;
		door_armed = 1'b0;
		classic_begun = 1'b0;
		classic_prev_seen = 1'b0;
		classic_prev_rssi = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: close while unarmed, grace boundary, every phase move, classic edges
		queue_sighting(rpd_pkg::MODE_SCAN, -90, 1'b1, 1'b0, 1'b0, 32'd20000);
		queue_sighting(rpd_pkg::MODE_SCAN, -90, 1'b1, 1'b1, 1'b1, 32'd20000);
		queue_sighting(rpd_pkg::MODE_CLASSIC, 0, 1'b0, 1'b1, 1'b1, 32'd0);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -128, 1'b0, 1'b0, 1'b1, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, -95, 1'b1, 1'b0, 1'b1, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, -80, 1'b1, 1'b0, 1'b1, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, -81, 1'b1, 1'b0, 1'b0, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, -60, 1'b1, 1'b0, 1'b0, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, -81, 1'b1, 1'b0, 1'b0, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, 0, 1'b1, 1'b1, 1'b0, 32'd9999);
		queue_sighting(rpd_pkg::MODE_SCAN, -55, 1'b1, 1'b0, 1'b0, 32'd10000);
		queue_sighting(rpd_pkg::MODE_SCAN, -96, 1'b1, 1'b0, 1'b0, 32'd10000);
		queue_sighting(rpd_pkg::MODE_SCAN, -128, 1'b1, 1'b0, 1'b1, 32'd10000);
		queue_sighting(rpd_pkg::MODE_SCAN, 0, 1'b0, 1'b0, 1'b1, 32'd10000);
		queue_sighting(rpd_pkg::MODE_SCAN, -56, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
		queue_sighting(rpd_pkg::MODE_SCAN, -128, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -90, 1'b1, 1'b0, 1'b1, 32'd54321);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -86, 1'b1, 1'b0, 1'b1, 32'd54321);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -85, 1'b1, 1'b0, 1'b1, 32'd54321);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -75, 1'b1, 1'b0, 1'b1, 32'd54321);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -128, 1'b1, 1'b0, 1'b0, 32'd54321);
		queue_sighting(rpd_pkg::MODE_CLASSIC, -128, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
		queue_sighting(rpd_pkg::MODE_CLASSIC, 0, 1'b1, 1'b0, 1'b1, 32'd0);
		queue_sighting(rpd_pkg::MODE_SCAN, 0, 1'b1, 1'b0, 1'b1, 32'd0);
		wait_drained();

		run_random_phase(RANDOM_PHASE);
		wait_drained();

		// lowest thresholds, no grace
		set_thresholds(-128, -128, -128, 0);
		run_random_phase(RANDOM_PHASE);
		wait_drained();

		// highest thresholds, longest grace
		set_thresholds(0, 0, 0, 65535);
		run_random_phase(RANDOM_PHASE);
		wait_drained();

		// ordered random thresholds
		ap = -int'($urandom_range(70, 128));
		st = ap + int'($urandom_range(0, 30));
		su = st + int'($urandom_range(0, 40));
		set_thresholds(ap, st, su, $urandom_range(0, 65535));
		run_random_phase(RANDOM_PHASE);
		wait_drained();

		// thresholds in any order
		set_thresholds(-int'($urandom_range(0, 128)), -int'($urandom_range(0, 128)),
			-int'($urandom_range(0, 128)), $urandom_range(0, 65535));
		run_random_phase(RANDOM_PHASE);
		wait_drained();

		repeat (6) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("rssi_proximity_door_fsm_unit test passed");
		end else begin
			$display("rssi_proximity_door_fsm_unit test failed");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5000000;
		$display("rssi_proximity_door_fsm_unit test failed");
		$finish;
	end

endmodule
